/* sv/assert_macros.svh */
// assertion helpers for the rtl of the packet cipher core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define CLPC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clpc assertion failed");

// next-cycle implication, disabled while reset is high
`define CLPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("clpc assertion failed");

`endif

/* sv/clpc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clpc_pkg
// Shared types and constants of the chained lcg packet cipher.
// ---------------------------------------------------------------------------
package clpc_pkg;

   // queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // configuration register indexes
   localparam int unsigned CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] REG_KEY    = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] REG_ENABLE = 1'b1;

   // generator constants (schrage-style lcg)
   localparam logic [31:0] LCG_MAGIC   = 32'h834E0B5F;
   localparam logic [16:0] LCG_MODULUS = 17'h1F31D;
   localparam logic [14:0] LCG_MULT    = 15'd16807;
   localparam logic [11:0] LCG_CROSS   = 12'd2836;
   localparam logic [31:0] LCG_INC     = 32'd123;
   localparam logic [31:0] LCG_FOLD    = 32'h7FFFFFFF;

   // reciprocal of the modulus, exact floor quotient for any 32-bit value
   localparam logic [32:0] LCG_RECIP   =
      33'(((64'd1 << 49) + 64'(LCG_MODULUS) - 64'd1) / 64'(LCG_MODULUS));

   // packet header tracking in the front
   typedef enum logic [3:0] {
      HDR_FIRST  = 4'b0001,
      HDR_SECOND = 4'b0010,
      HDR_BODY   = 4'b0100,
      HDR_PLAIN  = 4'b1000
   } hdr_pos_type;

   // back sequencer
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL  = 6'b000010,
      ST_MOD  = 6'b000100,
      ST_MIX  = 6'b001000,
      ST_XOR  = 6'b010000,
      ST_EMIT = 6'b100000
   } back_state_type;

   // one queued job: a plain byte or a body word
   typedef struct packed {
      logic        is_word;  // 1 body word, 0 byte passed unchanged
      logic        seed;     // first word of packet: reload generator and chain
      logic        dir;      // 0 encrypt, 1 decrypt
      logic        last;     // ends the packet
      logic [1:0]  top_idx;  // valid bytes minus one
      logic [31:0] key;      // key sampled at byte 0
      logic [31:0] word;     // body word, or the plain byte in the low bits
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

/* sv/clpc_fifo.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clpc_fifo
// Short job queue that decouples the classifying front from the cipher back.
// ---------------------------------------------------------------------------
module clpc_fifo import clpc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head_entry,
   output queue_status_type status
);

   entry_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]     count_ff, count_in;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry   = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

/* sv/clpc_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clpc_front
// Accepts packet bytes, tracks the header, gathers body words into jobs.
// ---------------------------------------------------------------------------
module clpc_front import clpc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // data_byte
   input  logic             req_tuser,   // opcode
   input  logic             req_tlast,   // last_in
   input  logic [31:0]      cfg_key,
   input  logic             cfg_enable,
   input  queue_status_type queue_status,
   output logic             push,
   output entry_type        push_entry
);

   hdr_pos_type  pos_ff, pos_in;
   logic         long_ff, long_in;
   logic         dir_ff, dir_in;
   logic         seed_ff, seed_in;
   logic [31:0]  key_ff, key_in;
   logic [23:0]  held_ff, held_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         take;
   logic         body_byte;
   logic [31:0]  assembled;

   assign req_tready = !queue_status.full;
   assign take       = req_tvalid && req_tready;

   // new byte merged into the partial word
   assign assembled = {8'd0, held_ff} | ({24'd0, req_tdata} << {cnt_ff, 3'b000});

   // classify the transaction and build the job
   always_comb begin
      pos_in    = pos_ff;
      long_in   = long_ff;
      dir_in    = dir_ff;
      seed_in   = seed_ff;
      key_in    = key_ff;
      held_in   = held_ff;
      cnt_in    = cnt_ff;
      push      = 1'b0;
      body_byte = 1'b0;

      push_entry.is_word = 1'b0;
      push_entry.seed    = seed_ff;
      push_entry.dir     = dir_ff;
      push_entry.last    = req_tlast;
      push_entry.top_idx = cnt_ff;
      push_entry.key     = key_ff;
      push_entry.word    = {24'd0, req_tdata};

      if (take) begin
         case (pos_ff)
            HDR_FIRST: begin
               push    = 1'b1;
               dir_in  = req_tuser;
               key_in  = cfg_key;
               held_in = '0;
               cnt_in  = '0;
               seed_in = 1'b1;
               long_in = (req_tdata == 8'd0);
               if (req_tlast) begin
                  pos_in = HDR_FIRST;
               end else if (cfg_enable) begin
                  pos_in = HDR_SECOND;
               end else begin
                  pos_in = HDR_PLAIN;
               end
            end
            HDR_PLAIN: begin
               push = 1'b1;
               if (req_tlast) begin
                  pos_in = HDR_FIRST;
               end
            end
            HDR_SECOND: begin
               if (long_ff) begin
                  push   = 1'b1;
                  pos_in = req_tlast ? HDR_FIRST : HDR_BODY;
               end else begin
                  body_byte = 1'b1;
                  pos_in    = HDR_BODY;
               end
            end
            HDR_BODY: begin
               body_byte = 1'b1;
            end
            default: begin
               pos_in = HDR_FIRST;
            end
         endcase
      end

      // body byte: hold, or close the word on the fourth byte or the last mark
      if (body_byte) begin
         if (cnt_ff == 2'd3 || req_tlast) begin
            push               = 1'b1;
            push_entry.is_word = 1'b1;
            push_entry.word    = assembled;
            seed_in            = 1'b0;
            held_in            = '0;
            cnt_in             = '0;
            if (req_tlast) begin
               pos_in = HDR_FIRST;
            end
         end else begin
            held_in = assembled[23:0];
            cnt_in  = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= HDR_FIRST;
         long_ff <= 1'b0;
         dir_ff  <= 1'b0;
         seed_ff <= 1'b0;
         held_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         pos_ff  <= pos_in;
         long_ff <= long_in;
         dir_ff  <= dir_in;
         seed_ff <= seed_in;
         held_ff <= held_in;
         cnt_ff  <= cnt_in;
      end
   end

   // latched key travels with the jobs
   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

/* sv/clpc_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clpc_back
// Runs the keystream generator, applies the chained xor, emits result bytes.
// ---------------------------------------------------------------------------
module clpc_back import clpc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  entry_type        head_entry,
   input  queue_status_type queue_status,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,   // out_byte
   output logic             rsp_tlast    // last_out
);

   back_state_type state_ff, state_in;
   logic           half_ff, half_in;
   logic [31:0]    v_ff, v_in;
   logic [31:0]    chain_ff, chain_in;
   logic [31:0]    word_ff, word_in;
   logic [31:0]    res_ff, res_in;
   logic [15:0]    ks_lo_ff, ks_lo_in;
   logic [15:0]    ks_hi_ff, ks_hi_in;
   logic [15:0]    t_ff, t_in;
   logic [15:0]    quot_ff, quot_in;
   logic [16:0]    rem_ff, rem_in;
   logic [31:0]    tk_ff, tk_in;
   logic [1:0]     top_ff, top_in;
   logic [1:0]     idx_ff, idx_in;
   logic           last_ff, last_in;
   logic           dir_ff, dir_in;
   logic           out_valid_ff, out_valid_in;
   logic [7:0]     out_byte_ff, out_byte_in;
   logic           out_last_ff, out_last_in;

   logic           can_load;
   logic           load;
   logic [63:0]    magic_prod;
   logic [64:0]    recip_prod;
   logic [32:0]    quot_prod;
   logic [31:0]    diff;
   logic [31:0]    mix_sum;
   logic [31:0]    mix_fold;
   logic [31:0]    res_word;
   logic [31:0]    res_shift;

   assign can_load = !out_valid_ff || rsp_tready;

   // generator arithmetic, one stage per state
   assign magic_prod = 64'(v_ff) * 64'(LCG_MAGIC);
   // exact quotient by reciprocal multiply, so the remainder needs no fixup
   assign recip_prod = 65'(v_ff) * 65'(LCG_RECIP);
   assign quot_prod  = 33'(quot_ff) * 33'(LCG_MODULUS);
   assign diff       = v_ff - quot_prod[31:0];
   assign mix_sum   = 32'(rem_ff) * 32'(LCG_MULT) - tk_ff + LCG_INC;
   assign mix_fold  = mix_sum[31] ? (mix_sum + LCG_FOLD) : mix_sum;
   assign res_word  = chain_ff ^ {ks_hi_ff, ks_lo_ff} ^ word_ff;
   assign res_shift = res_ff >> {idx_ff, 3'b000};

   // sequencer
   always_comb begin
      state_in    = state_ff;
      half_in     = half_ff;
      v_in        = v_ff;
      chain_in    = chain_ff;
      word_in     = word_ff;
      res_in      = res_ff;
      ks_lo_in    = ks_lo_ff;
      ks_hi_in    = ks_hi_ff;
      t_in        = t_ff;
      quot_in     = quot_ff;
      rem_in      = rem_ff;
      tk_in       = tk_ff;
      top_in      = top_ff;
      idx_in      = idx_ff;
      last_in     = last_ff;
      dir_in      = dir_ff;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      pop         = 1'b0;
      load        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!queue_status.empty) begin
               if (head_entry.is_word) begin
                  pop      = 1'b1;
                  word_in  = head_entry.word;
                  top_in   = head_entry.top_idx;
                  last_in  = head_entry.last;
                  dir_in   = head_entry.dir;
                  half_in  = 1'b0;
                  state_in = ST_MUL;
                  if (head_entry.seed) begin
                     v_in     = head_entry.key;
                     chain_in = head_entry.key;
                  end
               end else if (can_load) begin
                  pop         = 1'b1;
                  load        = 1'b1;
                  out_byte_in = head_entry.word[7:0];
                  out_last_in = head_entry.last;
               end
            end
         end
         ST_MUL: begin
            t_in     = magic_prod[63:48];
            quot_in  = recip_prod[64:49];
            state_in = ST_MOD;
         end
         ST_MOD: begin
            rem_in   = diff[16:0];
            tk_in    = 32'(t_ff * 28'(LCG_CROSS));
            state_in = ST_MIX;
         end
         ST_MIX: begin
            v_in = mix_fold;
            if (!half_ff) begin
               ks_lo_in = mix_fold[15:0];
               half_in  = 1'b1;
               state_in = ST_MUL;
            end else begin
               ks_hi_in = mix_fold[15:0];
               state_in = ST_XOR;
            end
         end
         ST_XOR: begin
            res_in   = res_word;
            chain_in = dir_ff ? word_ff : res_word;
            idx_in   = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (can_load) begin
               load        = 1'b1;
               out_byte_in = res_shift[7:0];
               out_last_in = last_ff && (idx_ff == top_ff);
               if (idx_ff == top_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register valid
   always_comb begin
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      half_ff     <= half_in;
      v_ff        <= v_in;
      chain_ff    <= chain_in;
      word_ff     <= word_in;
      res_ff      <= res_in;
      ks_lo_ff    <= ks_lo_in;
      ks_hi_ff    <= ks_hi_in;
      t_ff        <= t_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      tk_ff       <= tk_in;
      top_ff      <= top_in;
      idx_ff      <= idx_in;
      last_ff     <= last_in;
      dir_ff      <= dir_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

/* sv/chained_lcg_packet_cipher_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chained_lcg_packet_cipher_core
// Packet cipher: header bytes pass, body words xor with lcg keystream and chain.
// ---------------------------------------------------------------------------
// usage
//   req channel takes one packet byte per transaction, opcode in tuser
//   (0 encrypt, 1 decrypt) and the packet end in tlast. rsp channel returns
//   the bytes in order with tlast on the final byte of each packet.
//   csr port writes cipher_key (index 0) and cipher_enable (index 1); both
//   and the opcode are sampled at byte 0 of each packet.
// job flow
//   a byte that passes unchanged is registered in the job queue and then in the
//   output register; the back drains one such byte per cycle while rsp is not
//   stalled. a body word is handed over when its fourth byte (or the byte with
//   tlast) arrives; the back pops it, runs two generator steps (multiply,
//   reduce, mix each) and the xor, then emits its bytes one at a time, and
//   takes no new job until the word's last byte is out.
//   a 4-entry job queue lets the front keep accepting meanwhile.
// reset and stall
//   reset clears the header tracking, the queue and the output register;
//   key and enable reset to zero. a stalled rsp holds its byte and backs up
//   the queue, after which req_tready falls.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module chained_lcg_packet_cipher_core import clpc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // data_byte
   input  logic                  req_tuser,   // opcode
   input  logic                  req_tlast,   // last_in
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // out_byte
   output logic                  rsp_tlast,   // last_out
   input  logic                  csr_wen,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [31:0]           csr_wdata
);

   logic [31:0]      key_ff;
   logic             enable_ff;
   logic             push;
   logic             pop;
   entry_type        push_entry;
   entry_type        head_entry;
   queue_status_type queue_status;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff    <= '0;
         enable_ff <= 1'b0;
      end else if (csr_wen) begin
         case (csr_addr)
            REG_KEY: begin
               key_ff <= csr_wdata;
            end
            REG_ENABLE: begin
               enable_ff <= csr_wdata[0];
            end
            default: begin
               key_ff <= key_ff;
            end
         endcase
      end
   end

   clpc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .req_tlast    (req_tlast),
      .cfg_key      (key_ff),
      .cfg_enable   (enable_ff),
      .queue_status (queue_status),
      .push         (push),
      .push_entry   (push_entry)
   );

   clpc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (queue_status)
   );

   clpc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_entry   (head_entry),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

   // queue never overflows or underflows, and unpopped jobs stay queued
   `CLPC_ASSERT_IMPL(a_no_overflow, clock, reset, push, !queue_status.full)
   `CLPC_ASSERT_IMPL(a_no_underflow, clock, reset, pop, !queue_status.empty)
   `CLPC_ASSERT_NEXT(a_job_kept, clock, reset, !queue_status.empty && !pop, !queue_status.empty)

endmodule
